[design/shared_quota_pool_with_leases_unit_defines.svh]
// assertion macros shared by the quota pool rtl
`ifndef SHARED_QUOTA_POOL_WITH_LEASES_UNIT_DEFINES_SVH
`define SHARED_QUOTA_POOL_WITH_LEASES_UNIT_DEFINES_SVH
// implication checked on every rising clock edge outside reset
`define SQP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sqp assertion failed");
// next-cycle implication
`define SQP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sqp assertion failed");
`endif

[design/sqp_pkg.sv]
// ----------------------------------------------------------------------------
// sqp_pkg
// shared types and codes for the quota pool
// ----------------------------------------------------------------------------
`default_nettype none
package sqp_pkg;
  localparam logic [2:0] FUNC_REGISTER   = 3'd0;
  localparam logic [2:0] FUNC_UNREGISTER = 3'd1;
  localparam logic [2:0] FUNC_ACQUIRE    = 3'd2;
  localparam logic [2:0] FUNC_RELEASE    = 3'd3;
  localparam logic [2:0] FUNC_QUERY      = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DISABLED = 2'd1;
  localparam logic [1:0] ST_EXCEEDED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [2:0] REG_ENABLE  = 3'd0;
  localparam logic [2:0] REG_MAX_MEM = 3'd1;
  localparam logic [2:0] REG_MAX_CPU = 3'd2;
  localparam logic [2:0] REG_MAX_PRC = 3'd3;
  localparam logic [2:0] REG_TIMEOUT = 3'd4;

  localparam logic [31:0] TIMEOUT_RESET = 32'd60;

  // one slot table entry
  typedef struct packed {
    logic [15:0] token;
    logic [31:0] heartbeat;
    logic [31:0] mem;
    logic [15:0] cpu;
    logic [15:0] prc;
  } slot_t;

  // pool totals
  typedef struct packed {
    logic [31:0] mem;
    logic [15:0] cpu;
    logic [15:0] prc;
  } pool_t;
endpackage
`default_nettype wire

[design/sqp_release_unit.sv]
// ----------------------------------------------------------------------------
// sqp_release_unit
// shared saturating subtract of three holdings from the pool totals
// ----------------------------------------------------------------------------
`default_nettype none
module sqp_release_unit (
  input  var sqp_pkg::pool_t pool_i,
  input  var sqp_pkg::pool_t sub_i,
  output sqp_pkg::pool_t     res_o
);
  import sqp_pkg::*;
  // each field saturates at zero
  always_comb begin
    res_o.mem = (pool_i.mem >= sub_i.mem) ? pool_i.mem - sub_i.mem : '0;
    res_o.cpu = (pool_i.cpu >= sub_i.cpu) ? pool_i.cpu - sub_i.cpu : '0;
    res_o.prc = (pool_i.prc >= sub_i.prc) ? pool_i.prc - sub_i.prc : '0;
  end
endmodule
`default_nettype wire

[design/shared_quota_pool_with_leases_unit.sv]
// ----------------------------------------------------------------------------
// shared_quota_pool_with_leases_unit
// quota pool shared by up to SLOT_COUNT clients with heartbeat leases
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid_i/in_ready_o) carries one request item;
// the output channel (out_valid_o/out_ready_i) returns one result item per
// request. Configuration registers are written through cfg_valid_i/cfg_ready_o
// with cfg_index_i and cfg_data_i, by the user only while the block is idle;
// the block itself does not enforce this. One item at a time: an item is
// taken, then the sequencer walks the slot table once, one slot a cycle
// through a single shared subtract unit, for reclaim (acquire and query
// only), free-slot search and the live count. After the walk, the execute
// and done states register the result.
// The result stays in an output register and the pool totals hold with it;
// no further item is taken until the result is delivered, so a stalled
// receiver stalls the input.
// Reset empties the slot table (by per-slot valid bits), clears the pool
// totals, sets the token counter to one and the timeout to sixty seconds.
// ----------------------------------------------------------------------------
`default_nettype none
`include "shared_quota_pool_with_leases_unit_defines.svh"
module shared_quota_pool_with_leases_unit #(
  parameter int SLOT_COUNT = 16
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [2:0]  cfg_index_i,
  input  wire  [31:0] cfg_data_i,
  input  wire         in_valid_i,
  output logic        in_ready_o,
  input  wire  [2:0]  func_i,
  input  wire  [3:0]  client_slot_i,
  input  wire  [15:0] client_token_i,
  input  wire  [31:0] request_memory_i,
  input  wire  [15:0] request_cpu_i,
  input  wire  [15:0] request_processes_i,
  input  wire  [31:0] now_seconds_i,
  output logic        out_valid_o,
  input  wire         out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  granted_slot_o,
  output logic [15:0] granted_token_o,
  output logic [31:0] used_memory_o,
  output logic [15:0] used_cpu_o,
  output logic [15:0] active_process_total_o,
  output logic [4:0]  live_instances_o
);
  import sqp_pkg::*;

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = $clog2(SLOT_COUNT + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_EXEC = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic        en_q;
  logic [31:0] max_mem_q, timeout_q;
  logic [15:0] max_cpu_q, max_prc_q;

  // slot table, one valid (occupied) bit per slot
  slot_t             tab_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] occ_q;
  pool_t             pool_q;
  logic [15:0]       tcnt_q;

  // captured item
  logic [2:0]  func_q;
  logic [3:0]  cslot_q;
  logic [15:0] ctok_q, rcpu_q, rprc_q;
  logic [31:0] rmem_q, now_q;

  // scan bookkeeping
  logic [IW-1:0] idx_q;
  logic          free_found_q;
  logic [IW-1:0] free_idx_q;
  logic [CW-1:0] live_q;

  // output register
  logic        ovld_q;
  logic [1:0]  st_q, st_d;
  logic [3:0]  gslot_q, gslot_d;
  logic [15:0] gtok_q, gtok_d;
  logic [4:0]  olive_q, olive_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE) && !ovld_q;
  assign out_valid_o = ovld_q;
  assign status_o    = st_q;
  assign granted_slot_o  = gslot_q;
  assign granted_token_o = gtok_q;
  assign used_memory_o   = pool_q.mem;
  assign used_cpu_o      = pool_q.cpu;
  assign active_process_total_o = pool_q.prc;
  assign live_instances_o = olive_q;

  // current scanned slot and shared subtract unit
  slot_t cur;
  pool_t sub_in, sub_res;
  logic  reclaim_op, expired;
  logic [IW-1:0] own_idx;
  logic  own_in_range, owned;

  assign cur = tab_q[idx_q];
  assign reclaim_op = (func_q == FUNC_ACQUIRE) || (func_q == FUNC_QUERY);
  assign expired = occ_q[idx_q] && (now_q >= cur.heartbeat) &&
                   ((now_q - cur.heartbeat) > timeout_q);
  assign own_idx = IW'(cslot_q);
  assign own_in_range = ({28'd0, cslot_q} < 32'(SLOT_COUNT));
  assign owned = own_in_range && occ_q[own_idx] && (tab_q[own_idx].token == ctok_q);

  always_comb begin
    if (state_q == S_SCAN) begin
      sub_in = '{mem: cur.mem, cpu: cur.cpu, prc: cur.prc};
    end else if (func_q == FUNC_UNREGISTER) begin
      sub_in = '{mem: tab_q[own_idx].mem, cpu: tab_q[own_idx].cpu,
                 prc: tab_q[own_idx].prc};
    end else begin
      sub_in = '{mem: rmem_q, cpu: rcpu_q, prc: rprc_q};
    end
  end

  sqp_release_unit u_sub (
    .pool_i (pool_q),
    .sub_i  (sub_in),
    .res_o  (sub_res)
  );

  // acquire checks
  logic [32:0] sum_mem;
  logic [16:0] sum_cpu, sum_prc;
  logic        refuse;
  assign sum_mem = {1'b0, pool_q.mem} + {1'b0, rmem_q};
  assign sum_cpu = {1'b0, pool_q.cpu} + {1'b0, rcpu_q};
  assign sum_prc = {1'b0, pool_q.prc} + {1'b0, rprc_q};
  assign refuse = sum_mem[32] || ((max_mem_q != 0) && (sum_mem > {1'b0, max_mem_q})) ||
                  sum_cpu[16] || ((max_cpu_q != 0) && (sum_cpu > {1'b0, max_cpu_q})) ||
                  sum_prc[16] || ((max_prc_q != 0) && (sum_prc > {1'b0, max_prc_q}));

  // saturating slot additions
  logic [32:0] smem_add;
  logic [16:0] scpu_add, sprc_add;
  assign smem_add = {1'b0, tab_q[own_idx].mem} + {1'b0, rmem_q};
  assign scpu_add = {1'b0, tab_q[own_idx].cpu} + {1'b0, rcpu_q};
  assign sprc_add = {1'b0, tab_q[own_idx].prc} + {1'b0, rprc_q};

  logic bypass;
  assign bypass = !en_q || (func_q > FUNC_QUERY) ||
                  ((func_q != FUNC_REGISTER) && (ctok_q == 16'd0));

  // result fields of the executed item
  always_comb begin
    st_d = ST_OK;
    gslot_d = '0;
    gtok_d = '0;
    olive_d = '0;
    if (bypass) begin
      st_d = ((func_q == FUNC_UNREGISTER) && en_q) ? ST_OK : ST_DISABLED;
    end else begin
      case (func_q)
        FUNC_REGISTER: begin
          if (!free_found_q) begin
            st_d = ST_FULL;
          end else begin
            gslot_d = 4'(free_idx_q);
            gtok_d = tcnt_q;
          end
        end
        FUNC_ACQUIRE: if (refuse) st_d = ST_EXCEEDED;
        FUNC_QUERY:   olive_d = 5'(live_q);
        default: ;
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (in_valid_i && in_ready_o) state_d = S_SCAN;
      S_SCAN:  if (32'(idx_q) == SLOT_COUNT - 1) state_d = S_EXEC;
      S_EXEC:  state_d = S_DONE;
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      en_q <= 1'b0; max_mem_q <= '0; max_cpu_q <= '0; max_prc_q <= '0;
      timeout_q <= TIMEOUT_RESET;
      occ_q <= '0;
      for (int i = 0; i < SLOT_COUNT; i++) tab_q[i] <= '0;
      pool_q <= '0;
      tcnt_q <= 16'd1;
      ovld_q <= 1'b0;
      st_q <= ST_OK; gslot_q <= '0; gtok_q <= '0; olive_q <= '0;
      idx_q <= '0; free_found_q <= 1'b0; free_idx_q <= '0; live_q <= '0;
    end else begin
      state_q <= state_d;
      // configuration writes
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_ENABLE:  en_q <= cfg_data_i[0];
          REG_MAX_MEM: max_mem_q <= cfg_data_i;
          REG_MAX_CPU: max_cpu_q <= cfg_data_i[15:0];
          REG_MAX_PRC: max_prc_q <= cfg_data_i[15:0];
          REG_TIMEOUT: timeout_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (ovld_q && out_ready_i) ovld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          idx_q <= '0; free_found_q <= 1'b0; live_q <= '0;
        end
        // one slot per cycle: reclaim, free search, live count
        S_SCAN: begin
          if (!bypass && reclaim_op && expired) begin
            pool_q <= sub_res;
            occ_q[idx_q] <= 1'b0;
          end else if (occ_q[idx_q]) begin
            live_q <= live_q + CW'(1);
          end
          if (!occ_q[idx_q] && !free_found_q) begin
            free_found_q <= 1'b1;
            free_idx_q <= idx_q;
          end
          if (32'(idx_q) != SLOT_COUNT - 1) idx_q <= idx_q + IW'(1);
        end
        S_EXEC: begin
          st_q <= st_d; gslot_q <= gslot_d; gtok_q <= gtok_d; olive_q <= olive_d;
          if (!bypass) begin
            case (func_q)
              FUNC_REGISTER: begin
                if (free_found_q) begin
                  occ_q[free_idx_q] <= 1'b1;
                  tab_q[free_idx_q] <= '{token: tcnt_q, heartbeat: now_q,
                                         mem: '0, cpu: '0, prc: '0};
                  tcnt_q <= (tcnt_q == 16'hFFFF) ? 16'd1 : tcnt_q + 16'd1;
                end
              end
              FUNC_UNREGISTER: if (owned) begin
                pool_q <= sub_res;
                occ_q[own_idx] <= 1'b0;
              end
              FUNC_ACQUIRE: begin
                if (!refuse) begin
                  pool_q <= '{mem: sum_mem[31:0], cpu: sum_cpu[15:0],
                              prc: sum_prc[15:0]};
                  if (owned) begin
                    tab_q[own_idx].mem <= smem_add[32] ? '1 : smem_add[31:0];
                    tab_q[own_idx].cpu <= scpu_add[16] ? '1 : scpu_add[15:0];
                    tab_q[own_idx].prc <= sprc_add[16] ? '1 : sprc_add[15:0];
                    tab_q[own_idx].heartbeat <= now_q;
                  end
                end
              end
              FUNC_RELEASE: begin
                pool_q <= sub_res;
                if (owned) begin
                  tab_q[own_idx].mem <= (tab_q[own_idx].mem >= rmem_q) ?
                                        tab_q[own_idx].mem - rmem_q : '0;
                  tab_q[own_idx].cpu <= (tab_q[own_idx].cpu >= rcpu_q) ?
                                        tab_q[own_idx].cpu - rcpu_q : '0;
                  tab_q[own_idx].prc <= (tab_q[own_idx].prc >= rprc_q) ?
                                        tab_q[own_idx].prc - rprc_q : '0;
                  tab_q[own_idx].heartbeat <= now_q;
                end
              end
              FUNC_QUERY: begin
                if (owned) tab_q[own_idx].heartbeat <= now_q;
              end
              default: ;
            endcase
          end
        end
        S_DONE: ovld_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // item capture
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      func_q <= func_i; cslot_q <= client_slot_i; ctok_q <= client_token_i;
      rmem_q <= request_memory_i; rcpu_q <= request_cpu_i;
      rprc_q <= request_processes_i; now_q <= now_seconds_i;
    end
  end

  `SQP_ASSERT_IMP(a_no_accept_busy, clk_i, rst_ni, state_q != S_IDLE, !in_ready_o)
  `SQP_ASSERT_NXT(a_done_valid, clk_i, rst_ni, state_q == S_DONE, out_valid_o)
  `SQP_ASSERT_IMP(a_token_nonzero, clk_i, rst_ni, 1'b1, tcnt_q != 16'd0)
  `SQP_ASSERT_IMP(a_exec_after_scan, clk_i, rst_ni, state_q == S_EXEC, $past(state_q) == S_SCAN)
endmodule
`default_nettype wire

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives requests and config writes into the quota pool, predicts each
// result from a behavioural copy of the pool and checks every result field
// ----------------------------------------------------------------------------
`default_nettype none

// scoreboard: behavioural pool state plus queue of expected results
class quota_scoreboard;
  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  gslot;
    logic [15:0] gtok;
    logic [31:0] mem;
    logic [15:0] cpu;
    logic [15:0] prc;
    logic [4:0]  live;
  } result_t;

  bit          enabled;
  bit [31:0]   lim_mem;
  bit [15:0]   lim_cpu;
  bit [15:0]   lim_prc;
  bit [31:0]   timeout;
  bit [15:0]   tok [16];
  bit [31:0]   hb [16];
  bit [31:0]   smem [16];
  bit [15:0]   scpu [16];
  bit [15:0]   sprc [16];
  bit [31:0]   pmem;
  bit [15:0]   pcpu;
  bit [15:0]   pprc;
  bit [15:0]   next_tok;
  result_t     pending [$];
  int          mismatches;

  function new();
    enabled = 0; lim_mem = 0; lim_cpu = 0; lim_prc = 0;
    timeout = sqp_pkg::TIMEOUT_RESET;
    for (int i = 0; i < 16; i++) begin
      tok[i] = 0; hb[i] = 0; smem[i] = 0; scpu[i] = 0; sprc[i] = 0;
    end
    pmem = 0; pcpu = 0; pprc = 0; next_tok = 1; mismatches = 0;
  endfunction

  function void write_reg(logic [2:0] idx, logic [31:0] d);
    case (idx)
      sqp_pkg::REG_ENABLE:  enabled = d[0];
      sqp_pkg::REG_MAX_MEM: lim_mem = d;
      sqp_pkg::REG_MAX_CPU: lim_cpu = d[15:0];
      sqp_pkg::REG_MAX_PRC: lim_prc = d[15:0];
      sqp_pkg::REG_TIMEOUT: timeout = d;
      default: ;
    endcase
  endfunction

  function void drop_slot(int i);
    pmem = (pmem >= smem[i]) ? pmem - smem[i] : 0;
    pcpu = (pcpu >= scpu[i]) ? pcpu - scpu[i] : 0;
    pprc = (pprc >= sprc[i]) ? pprc - sprc[i] : 0;
    tok[i] = 0; hb[i] = 0; smem[i] = 0; scpu[i] = 0; sprc[i] = 0;
  endfunction

  function void expire(bit [31:0] now);
    for (int i = 0; i < 16; i++)
      if (tok[i] != 0 && now >= hb[i] && now - hb[i] > timeout) drop_slot(i);
  endfunction

  // note an accepted request and queue the result it must produce
  function void note_request(bit [2:0] fn, bit [3:0] cs, bit [15:0] ct, bit [31:0] rm,
                             bit [15:0] rc, bit [15:0] rp, bit [31:0] now);
    result_t r;
    int      i;
    bit      own;
    bit [32:0] sm;
    bit [16:0] sc, sp;
    r = '0;
    own = (tok[cs] == ct);
    if (!enabled || fn > sqp_pkg::FUNC_QUERY) begin
      r.status = sqp_pkg::ST_DISABLED;
    end else if (fn == sqp_pkg::FUNC_REGISTER) begin
      for (i = 0; i < 16; i++) if (tok[i] == 0) break;
      if (i >= 16) r.status = sqp_pkg::ST_FULL;
      else begin
        tok[i] = next_tok; hb[i] = now; smem[i] = 0; scpu[i] = 0; sprc[i] = 0;
        r.gslot = 4'(i); r.gtok = next_tok;
        next_tok++;
        if (next_tok == 0) next_tok = 1;
      end
    end else if (ct == 0) begin
      r.status = (fn == sqp_pkg::FUNC_UNREGISTER) ? sqp_pkg::ST_OK : sqp_pkg::ST_DISABLED;
    end else if (fn == sqp_pkg::FUNC_UNREGISTER) begin
      if (own) drop_slot(cs);
    end else if (fn == sqp_pkg::FUNC_ACQUIRE) begin
      expire(now);
      own = (tok[cs] == ct);
      sm = pmem + rm; sc = pcpu + rc; sp = pprc + rp;
      if (sm[32] || (lim_mem != 0 && sm > lim_mem) || sc[16] ||
          (lim_cpu != 0 && sc > lim_cpu) || sp[16] || (lim_prc != 0 && sp > lim_prc)) begin
        r.status = sqp_pkg::ST_EXCEEDED;
      end else begin
        pmem = sm[31:0]; pcpu = sc[15:0]; pprc = sp[15:0];
        if (own) begin
          sm = smem[cs] + rm; smem[cs] = sm[32] ? 32'hFFFF_FFFF : sm[31:0];
          sc = scpu[cs] + rc; scpu[cs] = sc[16] ? 16'hFFFF : sc[15:0];
          sp = sprc[cs] + rp; sprc[cs] = sp[16] ? 16'hFFFF : sp[15:0];
          hb[cs] = now;
        end
      end
    end else if (fn == sqp_pkg::FUNC_RELEASE) begin
      pmem = (pmem >= rm) ? pmem - rm : 0;
      pcpu = (pcpu >= rc) ? pcpu - rc : 0;
      pprc = (pprc >= rp) ? pprc - rp : 0;
      if (own) begin
        smem[cs] = (smem[cs] >= rm) ? smem[cs] - rm : 0;
        scpu[cs] = (scpu[cs] >= rc) ? scpu[cs] - rc : 0;
        sprc[cs] = (sprc[cs] >= rp) ? sprc[cs] - rp : 0;
        hb[cs] = now;
      end
    end else begin
      expire(now);
      for (i = 0; i < 16; i++) if (tok[i] != 0) r.live++;
      if (tok[cs] == ct) hb[cs] = now;
    end
    r.mem = pmem; r.cpu = pcpu; r.prc = pprc;
    pending.push_back(r);
  endfunction

  // compare a delivered result with the oldest expectation
  function void check_result(result_t got);
    result_t want;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result item %h", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("result mismatch: expected st=%0d sl=%0d tk=%0d m=%0d c=%0d p=%0d l=%0d, got st=%0d sl=%0d tk=%0d m=%0d c=%0d p=%0d l=%0d",
                 want.status, want.gslot, want.gtok, want.mem, want.cpu, want.prc, want.live,
                 got.status, got.gslot, got.gtok, got.mem, got.cpu, got.prc, got.live);
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sqp_pkg::*;

  localparam int LATENCY = 19;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        cfg_valid_i = 0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = 0;
  logic [31:0] cfg_data_i = 0;
  logic        in_valid_i = 0;
  logic        in_ready_o;
  logic [2:0]  func_i = 0;
  logic [3:0]  client_slot_i = 0;
  logic [15:0] client_token_i = 0;
  logic [31:0] request_memory_i = 0;
  logic [15:0] request_cpu_i = 0;
  logic [15:0] request_processes_i = 0;
  logic [31:0] now_seconds_i = 0;
  logic        out_valid_o;
  logic        out_ready_i = 0;
  logic [1:0]  status_o;
  logic [3:0]  granted_slot_o;
  logic [15:0] granted_token_o;
  logic [31:0] used_memory_o;
  logic [15:0] used_cpu_o;
  logic [15:0] active_process_total_o;
  logic [4:0]  live_instances_o;

  shared_quota_pool_with_leases_unit dut (.*);

  always #5 clk_i = ~clk_i;

  quota_scoreboard pool = new();
  bit        idle_on = 1;
  bit        hold_off = 0;
  int        cycles = 0;
  bit [31:0] clock_now = 100;
  bit [15:0] known_tok [16];

  // cycle limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // result side: random stalls, long hold-off on request, check on accept
  initial begin
    int gap;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        pool.check_result({status_o, granted_slot_o, granted_token_o, used_memory_o,
                           used_cpu_o, active_process_total_o, live_instances_o});
        if (granted_token_o != 0) known_tok[granted_slot_o] = granted_token_o;
      end
      if (hold_off) out_ready_i <= 0;
      else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 0;
        gap = $urandom_range(1, 17);
        repeat (gap) @(posedge clk_i);
        out_ready_i <= 1;
      end else out_ready_i <= 1;
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [31:0] d);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    pool.write_reg(idx, d);
    cfg_valid_i <= 0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (pool.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic send(bit [2:0] fn, bit [3:0] cs, bit [15:0] ct, bit [31:0] rm,
                      bit [15:0] rc, bit [15:0] rp, bit [31:0] now);
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1; func_i <= fn; client_slot_i <= cs; client_token_i <= ct;
    request_memory_i <= rm; request_cpu_i <= rc; request_processes_i <= rp;
    now_seconds_i <= now;
    do @(posedge clk_i); while (!in_ready_o);
    pool.note_request(fn, cs, ct, rm, rc, rp, now);
  endtask

  // one random request, mostly with a known token; sane memory in mode 1
  task automatic random_request(int mode);
    bit [2:0]  fn;
    bit [3:0]  cs;
    bit [15:0] ct;
    bit [31:0] rm;
    int        k;
    k = $urandom_range(0, 99);
    fn = (k < 20) ? FUNC_REGISTER : (k < 28) ? FUNC_UNREGISTER : (k < 60) ? FUNC_ACQUIRE :
         (k < 80) ? FUNC_RELEASE : (k < 97) ? FUNC_QUERY : 3'($urandom_range(5, 7));
    cs = $urandom_range(0, 15);
    ct = ($urandom_range(0, 9) < 8) ? known_tok[cs] : 16'($urandom);
    if ($urandom_range(0, 30) == 0) ct = 0;
    rm = (mode == 0 || $urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 600);
    clock_now += $urandom_range(0, 12);
    send(fn, cs, ct, rm,
         ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
         ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)),
         ($urandom_range(0, 40) == 0) ? $urandom : clock_now);
  endtask

  initial begin
    for (int i = 0; i < 16; i++) known_tok[i] = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: disabled pool, then enabled with extremes
    send(FUNC_REGISTER, 0, 0, 0, 0, 0, 5);
    drain();
    write_cfg(REG_ENABLE, 1);
    write_cfg(REG_TIMEOUT, 32'hFFFF_FFFF);
    for (int i = 0; i < 17; i++) send(FUNC_REGISTER, 0, 0, 0, 0, 0, 10);
    drain();
    send(FUNC_ACQUIRE, 0, known_tok[0], 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 11);
    send(FUNC_ACQUIRE, 1, known_tok[1], 1, 1, 1, 11);
    send(FUNC_QUERY, 0, 0, 0, 0, 0, 12);
    send(FUNC_RELEASE, 1, known_tok[1], 5, 5, 5, 12);
    send(FUNC_UNREGISTER, 0, known_tok[0], 0, 0, 0, 13);
    send(FUNC_UNREGISTER, 2, 0, 0, 0, 0, 13);
    send(3'd7, 0, 0, 0, 0, 0, 13);
    send(FUNC_QUERY, 3, known_tok[3], 0, 0, 0, 32'hFFFF_FFFF);
    send(FUNC_QUERY, 3, known_tok[3], 0, 0, 0, 0);
    drain();
    write_cfg(REG_TIMEOUT, 0);
    send(FUNC_QUERY, 0, 0, 0, 0, 0, 20);
    drain();
    write_cfg(REG_MAX_MEM, 1000);
    write_cfg(REG_MAX_CPU, 100);
    write_cfg(REG_MAX_PRC, 50);
    write_cfg(REG_TIMEOUT, 40);
    send(FUNC_REGISTER, 0, 0, 0, 0, 0, 30);
    send(FUNC_ACQUIRE, 0, 1, 1001, 0, 0, 30);
    send(FUNC_ACQUIRE, 0, 1, 0, 101, 0, 30);
    send(FUNC_ACQUIRE, 0, 1, 0, 0, 51, 30);
    send(FUNC_ACQUIRE, 0, 1, 1000, 100, 50, 30);
    drain();
    clock_now = 40;

    // random phases under different limits
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) idle_on = 0;
      for (int n = 0; n < 310; n++) random_request(ph % 2);
      if (ph == 2) begin
        // receiver holds off while requests keep coming
        fork
          begin hold_off = 1; repeat (300) @(posedge clk_i); hold_off = 0; end
          for (int n = 0; n < 20; n++) random_request(1);
        join
      end
      drain();
      write_cfg(REG_MAX_MEM, (ph % 3 == 0) ? 0 : (ph == 4 ? 32'hFFFF_FFFF : $urandom_range(500, 9000)));
      write_cfg(REG_MAX_CPU, (ph % 3 == 0) ? 0 : (ph == 4 ? 16'hFFFF : $urandom_range(50, 600)));
      write_cfg(REG_MAX_PRC, (ph % 3 == 0) ? 0 : (ph == 4 ? 16'hFFFF : $urandom_range(50, 600)));
      write_cfg(REG_TIMEOUT, $urandom_range(20, 200));
      if (ph == 3) begin
        write_cfg(REG_ENABLE, 0);
        for (int n = 0; n < 10; n++) random_request(1);
        drain();
        write_cfg(REG_ENABLE, 1);
      end
    end
    drain();
    if (pool.mismatches == 0 && pool.pending.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire

[filelist.f]
+incdir+design
design/sqp_pkg.sv
design/sqp_release_unit.sv
design/shared_quota_pool_with_leases_unit.sv
test/testbench.sv
